// File: src/cpp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cpp_pkg
// Types, constants and helpers shared by the collision plane projection
// block and its arithmetic units.
// ---------------------------------------------------------------------------
package cpp_pkg;

	typedef logic signed [31:0] coord_t;
	typedef logic signed [32:0] mop_t;
	typedef logic signed [65:0] mprod_t;

	typedef struct packed {
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic               first_vertex;
		logic               translation_invariant;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] proj_x;
		logic signed [31:0] proj_y;
		logic signed [31:0] proj_z;
		logic               last_of_constraint;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_CROSS,
		ST_NORM,
		ST_DOT,
		ST_DIV,
		ST_SHIFT,
		ST_ADD,
		ST_PTSC,
		ST_SCALE,
		ST_OUT
	} cpp_state_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

	localparam logic [23:0] WEIGHT_RESET = 24'd65536;
	localparam logic [1:0]  PHASE_LAST   = 2'd3;

	function automatic coord_t sat_sub(input coord_t a, input coord_t b);
		logic signed [32:0] d;
		d = {a[31], a} - {b[31], b};
		if (d[32] != d[31])
			sat_sub = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else
			sat_sub = d[31:0];
	endfunction

	function automatic coord_t sat_wide(input logic signed [55:0] v);
		if (v > 56'sd2147483647)
			sat_wide = 32'sh7fff_ffff;
		else if (v < -56'sd2147483648)
			sat_wide = 32'sh8000_0000;
		else
			sat_wide = v[31:0];
	endfunction

	function automatic logic [1:0] div3(input logic [3:0] i);
		unique case (i)
			4'd0, 4'd1, 4'd2: div3 = 2'd0;
			4'd3, 4'd4, 4'd5: div3 = 2'd1;
			default:          div3 = 2'd2;
		endcase
	endfunction

	function automatic logic [1:0] mod3(input logic [3:0] i);
		unique case (i)
			4'd0, 4'd3, 4'd6: mod3 = 2'd0;
			4'd1, 4'd4, 4'd7: mod3 = 2'd1;
			default:          mod3 = 2'd2;
		endcase
	endfunction

endpackage
`default_nettype wire

// File: src/cpp_mul.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cpp_mul
// Shared signed 33x33 multiplier with a registered product.
// ---------------------------------------------------------------------------
module cpp_mul (
	input  wire            clk,
	input  cpp_pkg::mop_t  a,
	input  cpp_pkg::mop_t  b,
	output cpp_pkg::mprod_t p_s1
);

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule
`default_nettype wire

// File: src/cpp_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cpp_div
// Restoring unsigned divider, 64-bit dividend by 34-bit divisor, one
// quotient bit per cycle.
// ---------------------------------------------------------------------------
module cpp_div (
	input  wire               clk,
	input  wire               arst_n,
	input  cpp_pkg::div_ctl_t ctl_in,
	input  wire [63:0]        dividend,
	input  wire [33:0]        divisor,
	output cpp_pkg::div_ctl_t ctl_out,
	output logic [63:0]       quotient
);

	logic [34:0] rem_q;
	logic [63:0] quo_q;
	logic [33:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [35:0] trial;

	assign trial = {1'b0, rem_q[33:0], quo_q[63]} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[35]) begin
				rem_q <= trial[34:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[33:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign ctl_out.start = 1'b0;
	assign ctl_out.done  = done_q;
	assign quotient      = quo_q;

endmodule
`default_nettype wire

// File: src/collision_plane_projection.sv
`default_nettype none
// ---------------------------------------------------------------------------
// collision_plane_projection
// Point against triangle plane collision projection, signed Q15.16.
// ---------------------------------------------------------------------------
// A point request and its three corner requests make one constraint. The
// fourth request starts a run on one shared 33x33 multiplier: cross
// product, normal scaling and, unless the triangle is degenerate, a dot
// product, plus a pass through the bit-serial divider when the point lies
// behind the plane, then the weight scaling. Input is stalled during the
// run and while the three results drain.
module collision_plane_projection (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  cpp_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output cpp_pkg::out_item_t  out_data,
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire  [2:0]          paddr,
	input  wire  [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	cpp_pkg::cpp_state_t state_q, state_d;
	logic [6:0]  cnt_q;
	logic [1:0]  phase_q;
	logic        inv_q;
	logic [23:0] weight_q;

	cpp_pkg::coord_t pt_q [3];
	cpp_pkg::coord_t c1_q [3];
	cpp_pkg::coord_t c2_q [3];
	cpp_pkg::coord_t c3_q [3];
	cpp_pkg::coord_t e1_q [3];
	cpp_pkg::coord_t e2_q [3];
	cpp_pkg::coord_t tp_q [3];
	logic signed [63:0] n_q  [3];
	logic signed [39:0] sh_q [3];
	logic signed [39:0] cv_q [9];
	logic signed [47:0] ps_q [3];
	cpp_pkg::coord_t    res_q [3][3];
	logic [63:0] mx_q;
	logic signed [63:0] dot_q, nn_q;
	logic signed [71:0] acc_q;
	logic signed [35:0] q_q;

	logic in_acc;
	logic [4:0] jj;
	logic [4:0] jo;
	cpp_pkg::mop_t  mul_a, mul_b;
	cpp_pkg::mprod_t p_s1;
	logic signed [71:0] pw;
	logic [63:0] mag0, mag1, mag2, mx_new;
	cpp_pkg::div_ctl_t div_in, div_out;
	logic [63:0] quo;
	logic [3:0] oi;

	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != cpp_pkg::ST_IDLE);
	assign pready = 1'b1;
	assign prdata = {8'd0, weight_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			weight_q <= cpp_pkg::WEIGHT_RESET;
		else if (psel && penable && pwrite && !paddr[2])
			weight_q <= pwdata[23:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cpp_pkg::ST_IDLE: begin
				if (in_acc && !in_data.first_vertex && phase_q == cpp_pkg::PHASE_LAST)
					state_d = cpp_pkg::ST_DIFF;
			end
			cpp_pkg::ST_DIFF: state_d = cpp_pkg::ST_CROSS;
			cpp_pkg::ST_CROSS: begin
				if (cnt_q == 7'd6)
					state_d = cpp_pkg::ST_NORM;
			end
			cpp_pkg::ST_NORM: begin
				if (cnt_q != 7'd0) begin
					if (mx_q == 64'd0)
						state_d = cpp_pkg::ST_PTSC;
					else if (!(|mx_q[63:30]) && mx_q[29])
						state_d = cpp_pkg::ST_DOT;
				end
			end
			cpp_pkg::ST_DOT: begin
				if (cnt_q == 7'd6)
					state_d = dot_q[63] ? cpp_pkg::ST_DIV : cpp_pkg::ST_PTSC;
			end
			cpp_pkg::ST_DIV: begin
				if (div_out.done)
					state_d = cpp_pkg::ST_SHIFT;
			end
			cpp_pkg::ST_SHIFT: begin
				if (cnt_q == 7'd6)
					state_d = cpp_pkg::ST_ADD;
			end
			cpp_pkg::ST_ADD: state_d = cpp_pkg::ST_PTSC;
			cpp_pkg::ST_PTSC: begin
				if (cnt_q == 7'd3)
					state_d = cpp_pkg::ST_SCALE;
			end
			cpp_pkg::ST_SCALE: begin
				if (cnt_q == 7'd18)
					state_d = cpp_pkg::ST_OUT;
			end
			cpp_pkg::ST_OUT: begin
				if (!out_stall && cnt_q == 7'd2)
					state_d = cpp_pkg::ST_IDLE;
			end
			default: state_d = cpp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpp_pkg::ST_IDLE;
			cnt_q   <= '0;
			phase_q <= '0;
			inv_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q)
				cnt_q <= '0;
			else if (state_q != cpp_pkg::ST_OUT || !out_stall)
				cnt_q <= cnt_q + 7'd1;
			if (in_acc) begin
				if (in_data.first_vertex) begin
					phase_q <= 2'd1;
					inv_q   <= in_data.translation_invariant;
				end else if (phase_q == cpp_pkg::PHASE_LAST)
					phase_q <= 2'd0;
				else if (phase_q != 2'd0)
					phase_q <= phase_q + 2'd1;
			end
		end
	end

	// operand select for the shared multiplier
	assign jj = cnt_q[4:0];
	assign jo = cnt_q[4:0] - 5'd1;

	always_comb begin
		logic [3:0] i;
		logic [1:0] c;
		i = jj[4:1];
		c = cpp_pkg::mod3(i);
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			cpp_pkg::ST_CROSS: begin
				unique case (jj[2:0])
					3'd0: begin mul_a = {e1_q[1][31], e1_q[1]}; mul_b = {e2_q[2][31], e2_q[2]}; end
					3'd1: begin mul_a = {e1_q[2][31], e1_q[2]}; mul_b = {e2_q[1][31], e2_q[1]}; end
					3'd2: begin mul_a = {e1_q[2][31], e1_q[2]}; mul_b = {e2_q[0][31], e2_q[0]}; end
					3'd3: begin mul_a = {e1_q[0][31], e1_q[0]}; mul_b = {e2_q[2][31], e2_q[2]}; end
					3'd4: begin mul_a = {e1_q[0][31], e1_q[0]}; mul_b = {e2_q[1][31], e2_q[1]}; end
					3'd5: begin mul_a = {e1_q[1][31], e1_q[1]}; mul_b = {e2_q[0][31], e2_q[0]}; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			cpp_pkg::ST_DOT: begin
				unique case (jj[2:0])
					3'd0: begin mul_a = {tp_q[0][31], tp_q[0]}; mul_b = n_q[0][32:0]; end
					3'd1: begin mul_a = {tp_q[1][31], tp_q[1]}; mul_b = n_q[1][32:0]; end
					3'd2: begin mul_a = {tp_q[2][31], tp_q[2]}; mul_b = n_q[2][32:0]; end
					3'd3: begin mul_a = n_q[0][32:0]; mul_b = n_q[0][32:0]; end
					3'd4: begin mul_a = n_q[1][32:0]; mul_b = n_q[1][32:0]; end
					3'd5: begin mul_a = n_q[2][32:0]; mul_b = n_q[2][32:0]; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			cpp_pkg::ST_SHIFT: begin
				if (jj < 5'd6) begin
					mul_b = n_q[jj[2:1]][32:0];
					if (!jj[0])
						mul_a = {{15{q_q[35]}}, q_q[35:18]};
					else
						mul_a = {15'd0, q_q[17:0]};
				end
			end
			cpp_pkg::ST_PTSC: begin
				if (jj < 5'd3) begin
					mul_a = {pt_q[jj[1:0]][31], pt_q[jj[1:0]]};
					mul_b = {9'd0, weight_q};
				end
			end
			cpp_pkg::ST_SCALE: begin
				if (jj < 5'd18) begin
					mul_b = {9'd0, weight_q};
					if (!jj[0])
						mul_a = {{11{cv_q[i][39]}}, cv_q[i][39:18]};
					else
						mul_a = {15'd0, cv_q[i][17:0]};
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		if (c == 2'd3)
			mul_a = '0;
	end

	cpp_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (p_s1)
	);

	assign pw = {{6{p_s1[65]}}, p_s1};

	assign mag0 = n_q[0][63] ? (64'd0 - n_q[0]) : n_q[0];
	assign mag1 = n_q[1][63] ? (64'd0 - n_q[1]) : n_q[1];
	assign mag2 = n_q[2][63] ? (64'd0 - n_q[2]) : n_q[2];
	always_comb begin
		mx_new = mag0;
		if (mag1 > mx_new)
			mx_new = mag1;
		if (mag2 > mx_new)
			mx_new = mag2;
	end

	assign div_in.start = (state_q == cpp_pkg::ST_DIV) && (cnt_q == 7'd0);
	assign div_in.done  = 1'b0;

	cpp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (div_in),
		.dividend (64'd0 - dot_q),
		.divisor  (nn_q[63:30]),
		.ctl_out  (div_out),
		.quotient (quo)
	);

	// datapath
	always_ff @(posedge clk) begin
		logic [3:0] i;
		logic [1:0] c;
		logic signed [71:0] sum;
		i = jo[4:1];
		c = cpp_pkg::mod3(i);
		sum = acc_q + pw;
		if (in_acc) begin
			if (in_data.first_vertex) begin
				pt_q[0] <= in_data.coord_x;
				pt_q[1] <= in_data.coord_y;
				pt_q[2] <= in_data.coord_z;
			end else if (phase_q == 2'd1) begin
				c1_q[0] <= in_data.coord_x;
				c1_q[1] <= in_data.coord_y;
				c1_q[2] <= in_data.coord_z;
			end else if (phase_q == 2'd2) begin
				c2_q[0] <= in_data.coord_x;
				c2_q[1] <= in_data.coord_y;
				c2_q[2] <= in_data.coord_z;
			end else begin
				c3_q[0] <= in_data.coord_x;
				c3_q[1] <= in_data.coord_y;
				c3_q[2] <= in_data.coord_z;
			end
		end
		unique case (state_q)
			cpp_pkg::ST_DIFF: begin
				for (int k = 0; k < 3; k++) begin
					e1_q[k] <= cpp_pkg::sat_sub(c2_q[k], c1_q[k]);
					e2_q[k] <= cpp_pkg::sat_sub(c3_q[k], c1_q[k]);
					tp_q[k] <= cpp_pkg::sat_sub(pt_q[k], c1_q[k]);
					n_q[k]  <= '0;
					sh_q[k] <= '0;
					cv_q[k]     <= 40'(c1_q[k]);
					cv_q[3 + k] <= 40'(c2_q[k]);
					cv_q[6 + k] <= 40'(c3_q[k]);
				end
			end
			cpp_pkg::ST_CROSS: begin
				if (cnt_q != 7'd0) begin
					if (!jo[0])
						n_q[jo[2:1]] <= n_q[jo[2:1]] + pw[64:1];
					else
						n_q[jo[2:1]] <= n_q[jo[2:1]] - pw[64:1];
				end
			end
			cpp_pkg::ST_NORM: begin
				if (cnt_q == 7'd0)
					mx_q <= mx_new;
				else if (|mx_q[63:30]) begin
					mx_q <= mx_q >> 1;
					for (int k = 0; k < 3; k++)
						n_q[k] <= n_q[k] >>> 1;
				end else if (!mx_q[29] && mx_q != 64'd0) begin
					mx_q <= mx_q << 1;
					for (int k = 0; k < 3; k++)
						n_q[k] <= n_q[k] <<< 1;
				end
			end
			cpp_pkg::ST_DOT: begin
				if (cnt_q == 7'd0) begin
					dot_q <= '0;
					nn_q  <= '0;
				end else if (jo < 5'd3)
					dot_q <= dot_q + pw[63:0];
				else
					nn_q <= nn_q + pw[63:0];
			end
			cpp_pkg::ST_DIV: begin
				if (div_out.done)
					q_q <= 36'sd0 - $signed(quo[35:0]);
			end
			cpp_pkg::ST_SHIFT: begin
				if (cnt_q != 7'd0) begin
					if (!jo[0])
						acc_q <= pw <<< 18;
					else
						sh_q[jo[2:1]] <= sum[69:30];
				end
			end
			cpp_pkg::ST_ADD: begin
				for (int k = 0; k < 9; k++)
					cv_q[k] <= cv_q[k] + sh_q[cpp_pkg::mod3(4'(k))];
			end
			cpp_pkg::ST_PTSC: begin
				if (cnt_q != 7'd0)
					ps_q[jo[1:0]] <= pw[63:16];
			end
			cpp_pkg::ST_SCALE: begin
				if (cnt_q != 7'd0) begin
					if (!jo[0])
						acc_q <= (pw <<< 18)
							- (inv_q ? ({{24{ps_q[c][47]}}, ps_q[c]} <<< 16) : 72'sd0);
					else
						res_q[cpp_pkg::div3(i)][c] <= cpp_pkg::sat_wide(sum[71:16]);
				end
			end
			default: begin
			end
		endcase
	end

	assign oi = {2'b00, cnt_q[1:0]};
	assign out_valid = (state_q == cpp_pkg::ST_OUT);
	assign out_data.proj_x = res_q[oi[1:0]][0];
	assign out_data.proj_y = res_q[oi[1:0]][1];
	assign out_data.proj_z = res_q[oi[1:0]][2];
	assign out_data.last_of_constraint = (oi == 4'd2);

endmodule
`default_nettype wire

// File: dv/tb_collision_plane_projection.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_collision_plane_projection
// Self-checking bench for the collision plane projection block: directed
// table of requests, then random constraints under fixed and random weights, checked
// against a behavioral predictor of the projection arithmetic.
// ---------------------------------------------------------------------------
module tb_collision_plane_projection;

	localparam int ADDR_WEIGHT = 0;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	cpp_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	cpp_pkg::out_item_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	collision_plane_projection dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [23:0] weight_q;
	longint held_q[9];
	int phase_q;
	bit inv_q;

	cpp_pkg::out_item_t proj_queue[$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 1'b0;

	typedef struct {
		cpp_pkg::in_item_t req;
		bit has_exp;
		cpp_pkg::out_item_t exp0;
	} row_t;

	row_t dir_table[$];

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint scale_w(longint v);
		return (v * longint'({40'd0, weight_q})) >>> 16;
	endfunction

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	task automatic predict_projection(input cpp_pkg::in_item_t r);
		longint v[3], pt[3], cr[3][3], e1[3], e2[3], tp[3], n[3], m[3];
		longint mx, dot, nn, d, q, sh, res;
		int s;
		cpp_pkg::out_item_t o;
		v[0] = r.coord_x; v[1] = r.coord_y; v[2] = r.coord_z;
		if (r.first_vertex) begin
			for (int c = 0; c < 3; c++) held_q[c] = v[c];
			inv_q = r.translation_invariant;
			phase_q = 1;
			return;
		end
		if (phase_q == 0) return;
		if (phase_q < 3) begin
			for (int c = 0; c < 3; c++) held_q[3 * phase_q + c] = v[c];
			phase_q++;
			return;
		end
		phase_q = 0;
		for (int c = 0; c < 3; c++) begin
			pt[c] = held_q[c];
			cr[0][c] = held_q[3 + c];
			cr[1][c] = held_q[6 + c];
			cr[2][c] = v[c];
			e1[c] = sat32(cr[1][c] - cr[0][c]);
			e2[c] = sat32(cr[2][c] - cr[0][c]);
			tp[c] = sat32(pt[c] - cr[0][c]);
		end
		n[0] = ((e1[1] * e2[2]) >>> 1) - ((e1[2] * e2[1]) >>> 1);
		n[1] = ((e1[2] * e2[0]) >>> 1) - ((e1[0] * e2[2]) >>> 1);
		n[2] = ((e1[0] * e2[1]) >>> 1) - ((e1[1] * e2[0]) >>> 1);
		mx = mag(n[0]);
		if (mag(n[1]) > mx) mx = mag(n[1]);
		if (mag(n[2]) > mx) mx = mag(n[2]);
		if (mx != 0) begin
			if (mx >= (64'sd1 << 30)) begin
				s = 0;
				while ((mx >> s) >= (64'sd1 << 30)) s++;
				for (int c = 0; c < 3; c++) m[c] = n[c] >>> s;
			end else begin
				s = 0;
				while ((mx << s) < (64'sd1 << 29)) s++;
				for (int c = 0; c < 3; c++) m[c] = n[c] <<< s;
			end
			dot = tp[0] * m[0] + tp[1] * m[1] + tp[2] * m[2];
			nn = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
			if (dot < 0) begin
				d = longint'(unsigned'(nn) >> 30);
				if (d != 0) begin
					q = dot / d;
					for (int c = 0; c < 3; c++) begin
						sh = (q * m[c]) >>> 30;
						for (int k = 0; k < 3; k++) cr[k][c] += sh;
					end
				end
			end
		end
		for (int k = 0; k < 3; k++) begin
			for (int c = 0; c < 3; c++) begin
				res = scale_w(cr[k][c]);
				if (inv_q) res -= scale_w(pt[c]);
				res = sat32(res);
				if (c == 0) o.proj_x = res[31:0];
				if (c == 1) o.proj_y = res[31:0];
				if (c == 2) o.proj_z = res[31:0];
			end
			o.last_of_constraint = (k == 2);
			proj_queue.insert(proj_queue.size(), o);
		end
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		$display("mismatch %s: got %h expected %h", what, got, exp);
		errors++;
	endtask

	// output side: check and random stall
	int stall_left = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (proj_queue.size() == 0) begin
				report("unexpected result", out_data.proj_x, '0);
			end else begin
				cpp_pkg::out_item_t e;
				e = proj_queue.pop_front();
				if (out_data.proj_x !== e.proj_x) report("proj_x", out_data.proj_x, e.proj_x);
				if (out_data.proj_y !== e.proj_y) report("proj_y", out_data.proj_y, e.proj_y);
				if (out_data.proj_z !== e.proj_z) report("proj_z", out_data.proj_z, e.proj_z);
				if (out_data.last_of_constraint !== e.last_of_constraint)
					report("last_of_constraint", 32'(out_data.last_of_constraint),
						32'(e.last_of_constraint));
			end
		end
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 14);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_weight(input logic [23:0] w);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 3'(ADDR_WEIGHT * 4); pwdata <= {8'd0, w};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		weight_q = w;
	endtask

	task automatic send(input cpp_pkg::in_item_t r);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (in_stall);
		predict_projection(r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (proj_queue.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_row(input cpp_pkg::in_item_t req, input bit has_exp,
		input cpp_pkg::out_item_t exp0);
		row_t row;
		row.req = req;
		row.has_exp = has_exp;
		row.exp0 = exp0;
		dir_table.insert(dir_table.size(), row);
	endtask

	function automatic cpp_pkg::in_item_t mk(input longint x, y, z, input bit f, input bit t);
		cpp_pkg::in_item_t r;
		r.coord_x = x[31:0]; r.coord_y = y[31:0]; r.coord_z = z[31:0];
		r.first_vertex = f; r.translation_invariant = t;
		return r;
	endfunction

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
		endcase
	endfunction

	initial begin
		cpp_pkg::in_item_t r;
		cpp_pkg::out_item_t e;
		longint big;
		weight_q = cpp_pkg::WEIGHT_RESET;
		phase_q = 0; inv_q = 0;
		for (int i = 0; i < 9; i++) held_q[i] = 0;
		big = 64'sd2147483647;

		// corner with no open constraint: ignored
		add_row(mk(5, 5, 5, 0, 1), 0, '0);
		// degenerate triangle, unit weight: results equal the corners
		add_row(mk(0, 0, -65536, 1, 0), 0, '0);
		add_row(mk(65536, 0, 0, 0, 1), 0, '0);
		add_row(mk(65536, 0, 0, 0, 0), 0, '0);
		e.proj_x = 32'sd65536; e.proj_y = 32'sd0; e.proj_z = 32'sd0;
		e.last_of_constraint = 1'b0;
		add_row(mk(65536, 0, 0, 0, 0), 1, e);
		// point behind z=0 plane, invariant
		add_row(mk(0, 0, -65536, 1, 1), 0, '0);
		add_row(mk(0, 0, 0, 0, 0), 0, '0);
		add_row(mk(65536, 0, 0, 0, 0), 0, '0);
		add_row(mk(0, 65536, 0, 0, 0), 0, '0);
		// point in front
		add_row(mk(0, 0, 65536, 1, 0), 0, '0);
		add_row(mk(0, 0, 0, 0, 0), 0, '0);
		add_row(mk(65536, 0, 0, 0, 0), 0, '0);
		add_row(mk(0, 65536, 0, 0, 0), 0, '0);
		// restart mid-constraint, then extremes
		add_row(mk(1, 2, 3, 1, 0), 0, '0);
		add_row(mk(4, 5, 6, 0, 0), 0, '0);
		add_row(mk(big, -big - 1, big, 1, 1), 0, '0);
		add_row(mk(-big - 1, -big - 1, -big - 1, 0, 1), 0, '0);
		add_row(mk(big, -big - 1, big, 0, 0), 0, '0);
		add_row(mk(-big - 1, big, big, 0, 0), 0, '0);
		add_row(mk(-1, -1, -1, 1, 0), 0, '0);
		add_row(mk(big, big, big, 0, 0), 0, '0);
		add_row(mk(-big - 1, big, -big - 1, 0, 0), 0, '0);
		add_row(mk(big, -big - 1, -big - 1, 0, 0), 0, '0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i]) begin
			send(dir_table[i].req);
			if (dir_table[i].has_exp && proj_queue.size() > 0 &&
				proj_queue[0] !== dir_table[i].exp0)
				report("directed table", proj_queue[0].proj_x, dir_table[i].exp0.proj_x);
		end
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_weight(24'd0);
				1: write_weight(24'hffffff);
				2: write_weight(24'd32768);
				default: write_weight(24'($urandom_range(0, 24'hffffff)));
			endcase
			if (ph == 4) quiet = 1'b1;
			for (int k = 0; k < 15; k++) begin
				int verts;
				verts = 4;
				if ($urandom_range(0, 9) == 0) verts = $urandom_range(1, 3);
				if ($urandom_range(0, 14) == 0) send(mk(rnd_coord(), 0, 0, 0, 1'($urandom)));
				for (int v = 0; v < verts; v++) begin
					r.coord_x = rnd_coord(); r.coord_y = rnd_coord(); r.coord_z = rnd_coord();
					r.first_vertex = (v == 0);
					r.translation_invariant = 1'($urandom_range(0, 1));
					send(r);
				end
				if (k == 7 && ph == 1) begin
					in_valid <= 1'b0;
					do @(posedge clk); while (proj_queue.size() != 0);
				end
			end
			drain();
		end

		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
src/cpp_pkg.sv
src/cpp_mul.sv
src/cpp_div.sv
src/collision_plane_projection.sv
dv/tb_collision_plane_projection.sv
